[rtl/core/tkifb_pkg.sv]
package tkifb_pkg;

   localparam int SLOTS       = 16;
   localparam int PEER_BITS   = 8;
   localparam int BUTTON_BITS = 8;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTH_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTH_PEER   = 1'd1;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TAKE    = 1'b1;

   localparam logic [2:0] ST_NEW      = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_DROPPED  = 3'd2;
   localparam logic [2:0] ST_TAKEN    = 3'd3;
   localparam logic [2:0] ST_NONE     = 3'd4;

   typedef struct packed {
      logic [31:0]            tick;
      logic [PEER_BITS-1:0]   peer;
      logic [BUTTON_BITS-1:0] buttons;
   } frame_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } stat_type;

endpackage

[rtl/core/tick_keyed_input_frame_buffer_unit.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    command, tick, peer, buttons
// rsp      out        rsp_valid/rsp_ready    status, tick, peer, buttons, four move flags
// csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Each request goes from acceptance through a scan of every slot, a drain and a commit step to a loaded result.
// The unit accepts no new request until the previous one has loaded its result.
// The scan over the frame memory reads one slot per cycle.
// Reset clears all slot valid bits; frame contents stay undefined.
// A finished result waits in the output register while the next request is accepted.
// A stalled result holds the unit only at the end of the following request.
module tick_keyed_input_frame_buffer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [31:0]                       req_tick,
   input  logic [7:0]                        req_peer,
   input  logic [7:0]                        req_buttons,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [31:0]                       rsp_out_tick,
   output logic [7:0]                        rsp_out_peer,
   output logic [7:0]                        rsp_out_buttons,
   output logic                              rsp_ahead,
   output logic                              rsp_reverse,
   output logic                              rsp_steer_left,
   output logic                              rsp_steer_right,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tkifb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tkifb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tkifb_pkg::cmd_type  cmd;
   tkifb_pkg::stat_type status;

   assign csr_ready = 1'b1;

   tkifb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tkifb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_command),
      .req_tick        (req_tick),
      .req_peer        (req_peer),
      .req_buttons     (req_buttons),
      .csr_write       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_out_tick    (rsp_out_tick),
      .rsp_out_peer    (rsp_out_peer),
      .rsp_out_buttons (rsp_out_buttons),
      .rsp_ahead       (rsp_ahead),
      .rsp_reverse     (rsp_reverse),
      .rsp_steer_left  (rsp_steer_left),
      .rsp_steer_right (rsp_steer_right)
   );

endmodule

[rtl/core/tkifb_ctrl.sv]
module tkifb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tkifb_pkg::stat_type status,
   output tkifb_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && rsp_valid_ff && !rsp_ready |=> state_ff == S_RESP)
      else $error("result dropped while output register was occupied");

endmodule

[rtl/core/tkifb_dp.sv]
module tkifb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tkifb_pkg::cmd_type                   cmd,
   output tkifb_pkg::stat_type                  status,
   input  logic                                 req_command,
   input  logic [31:0]                          req_tick,
   input  logic [7:0]                           req_peer,
   input  logic [7:0]                           req_buttons,
   input  logic                                 csr_write,
   input  logic [tkifb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tkifb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [2:0]                           rsp_status,
   output logic [31:0]                          rsp_out_tick,
   output logic [7:0]                           rsp_out_peer,
   output logic [7:0]                           rsp_out_buttons,
   output logic                                 rsp_ahead,
   output logic                                 rsp_reverse,
   output logic                                 rsp_steer_left,
   output logic                                 rsp_steer_right
);

   tkifb_pkg::frame_type frame_mem [tkifb_pkg::SLOTS];

   logic [tkifb_pkg::SLOTS-1:0]       slot_valid_ff;
   logic [tkifb_pkg::IDX_W-1:0]       cnt_ff;
   logic [tkifb_pkg::IDX_W-1:0]       rd_idx_ff;
   logic                              rd_live_ff;
   tkifb_pkg::frame_type              rd_frame_ff;

   logic                              cmd_ff;
   logic [31:0]                       tick_ff;
   logic [tkifb_pkg::PEER_BITS-1:0]   peer_ff;
   logic [tkifb_pkg::BUTTON_BITS-1:0] btn_ff;

   logic                              hit_ff;
   logic [tkifb_pkg::IDX_W-1:0]       hit_idx_ff;
   logic                              free_ff;
   logic [tkifb_pkg::IDX_W-1:0]       free_idx_ff;
   logic                              low_ff;
   tkifb_pkg::frame_type              low_frame_ff;
   logic                              auth_ff;
   tkifb_pkg::frame_type              auth_frame_ff;

   logic                              auth_en_ff;
   logic [7:0]                        auth_peer_ff;

   logic                              rd_slot_valid;
   logic                              rd_tick_eq;
   logic [tkifb_pkg::PEER_BITS-1:0]   want_peer;
   tkifb_pkg::frame_type              new_frame;
   tkifb_pkg::frame_type              pick;
   logic [2:0]                        res_status;
   logic                              res_taken;

   assign status.scan_last = (cnt_ff == tkifb_pkg::IDX_W'(tkifb_pkg::SLOTS - 1));

   assign rd_slot_valid = slot_valid_ff[rd_idx_ff];
   assign rd_tick_eq    = (rd_frame_ff.tick == tick_ff);
   assign want_peer     = (tkifb_pkg::PEER_BITS)'(auth_peer_ff);

   assign new_frame.tick    = tick_ff;
   assign new_frame.peer    = peer_ff;
   assign new_frame.buttons = btn_ff;

   assign pick = auth_ff ? auth_frame_ff : low_frame_ff;

   always_comb begin
      res_taken = 1'b0;
      if (cmd_ff == tkifb_pkg::CMD_ENQUEUE) begin
         if (hit_ff) begin
            res_status = tkifb_pkg::ST_REPLACED;
         end else if (free_ff) begin
            res_status = tkifb_pkg::ST_NEW;
         end else begin
            res_status = tkifb_pkg::ST_DROPPED;
         end
      end else begin
         res_taken  = low_ff;
         res_status = low_ff ? tkifb_pkg::ST_TAKEN : tkifb_pkg::ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_frame_ff <= frame_mem[cnt_ff];
      end
      if (cmd.commit && cmd_ff == tkifb_pkg::CMD_ENQUEUE) begin
         if (hit_ff) begin
            frame_mem[hit_idx_ff] <= new_frame;
         end else if (free_ff) begin
            frame_mem[free_idx_ff] <= new_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         cnt_ff        <= '0;
         rd_live_ff    <= 1'b0;
         cmd_ff        <= tkifb_pkg::CMD_ENQUEUE;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         low_ff        <= 1'b0;
         auth_ff       <= 1'b0;
         auth_en_ff    <= 1'b0;
         auth_peer_ff  <= '0;
      end else begin
         rd_live_ff <= cmd.issue;
         if (csr_write) begin
            unique case (csr_index)
               tkifb_pkg::CSR_AUTH_ENABLE: auth_en_ff   <= csr_wdata[0];
               tkifb_pkg::CSR_AUTH_PEER:   auth_peer_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            cmd_ff  <= req_command;
            cnt_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            low_ff  <= 1'b0;
            auth_ff <= 1'b0;
         end
         if (cmd.issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rd_live_ff) begin
            if (cmd_ff == tkifb_pkg::CMD_ENQUEUE) begin
               if (rd_slot_valid && rd_tick_eq && rd_frame_ff.peer == peer_ff) begin
                  hit_ff <= 1'b1;
               end
               if (!rd_slot_valid && !free_ff) begin
                  free_ff <= 1'b1;
               end
            end else if (rd_slot_valid && rd_tick_eq) begin
               slot_valid_ff[rd_idx_ff] <= 1'b0;
               if (!low_ff || rd_frame_ff.peer < low_frame_ff.peer) begin
                  low_ff <= 1'b1;
               end
               if (auth_en_ff && rd_frame_ff.peer == want_peer) begin
                  auth_ff <= 1'b1;
               end
            end
         end
         if (cmd.commit && cmd_ff == tkifb_pkg::CMD_ENQUEUE && !hit_ff && free_ff) begin
            slot_valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tick_ff <= req_tick;
         peer_ff <= (tkifb_pkg::PEER_BITS)'(req_peer);
         btn_ff  <= (tkifb_pkg::BUTTON_BITS)'(req_buttons);
      end
      if (cmd.issue) begin
         rd_idx_ff <= cnt_ff;
      end
      if (rd_live_ff) begin
         if (cmd_ff == tkifb_pkg::CMD_ENQUEUE) begin
            if (rd_slot_valid && rd_tick_eq && rd_frame_ff.peer == peer_ff) begin
               hit_idx_ff <= rd_idx_ff;
            end
            if (!rd_slot_valid && !free_ff) begin
               free_idx_ff <= rd_idx_ff;
            end
         end else if (rd_slot_valid && rd_tick_eq) begin
            if (!low_ff || rd_frame_ff.peer < low_frame_ff.peer) begin
               low_frame_ff <= rd_frame_ff;
            end
            if (auth_en_ff && rd_frame_ff.peer == want_peer) begin
               auth_frame_ff <= rd_frame_ff;
            end
         end
      end
      if (cmd.resp_load) begin
         rsp_status      <= res_status;
         rsp_out_tick    <= res_taken ? pick.tick : 32'd0;
         rsp_out_peer    <= res_taken ? 8'(pick.peer) : 8'd0;
         rsp_out_buttons <= res_taken ? 8'(pick.buttons) : 8'd0;
         rsp_ahead       <= res_taken & pick.buttons[0];
         rsp_reverse     <= res_taken & pick.buttons[1];
         rsp_steer_left  <= res_taken & pick.buttons[2];
         rsp_steer_right <= res_taken & pick.buttons[3];
      end
   end

   a_new_slot_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd_ff == tkifb_pkg::CMD_ENQUEUE && !hit_ff && free_ff
      |=> slot_valid_ff[$past(free_idx_ff)])
      else $error("stored frame did not mark its slot valid");

   a_take_never_sets: assert property (@(posedge clock) disable iff (reset)
      !cmd.load && cmd_ff == tkifb_pkg::CMD_TAKE
      |=> (slot_valid_ff & ~$past(slot_valid_ff)) == '0)
      else $error("take request marked a slot valid");

   a_enqueue_never_clears: assert property (@(posedge clock) disable iff (reset)
      !cmd.load && cmd_ff == tkifb_pkg::CMD_ENQUEUE
      |=> ($past(slot_valid_ff) & ~slot_valid_ff) == '0)
      else $error("enqueue request freed a slot");

   a_scan_done_before_commit: assert property (@(posedge clock) disable iff (reset)
      rd_live_ff |-> !cmd.commit && !cmd.load)
      else $error("scan data still in flight at commit or load");

endmodule

[tb/frame_store_checker.sv]
module frame_store_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_command,
   input  logic [31:0]                       req_tick,
   input  logic [7:0]                        req_peer,
   input  logic [7:0]                        req_buttons,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [2:0]                        rsp_status,
   input  logic [31:0]                       rsp_out_tick,
   input  logic [7:0]                        rsp_out_peer,
   input  logic [7:0]                        rsp_out_buttons,
   input  logic                              rsp_ahead,
   input  logic                              rsp_reverse,
   input  logic                              rsp_steer_left,
   input  logic                              rsp_steer_right,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tkifb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tkifb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] tick;
      logic [7:0]  peer;
      logic [7:0]  buttons;
      logic        forward;
      logic        backward;
      logic        left;
      logic        right;
   } frame_result_type;

   logic                 slot_held [tkifb_pkg::SLOTS];
   tkifb_pkg::frame_type slot_data [tkifb_pkg::SLOTS];
   logic                 auth_on;
   logic [7:0]           auth_id;
   frame_result_type     frame_result_q [$];
   frame_result_type     want_result;
   int                   mismatch_count = 0;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
      end
   endtask

   function automatic frame_result_type serve_request(input logic cmd,
                                                      input logic [31:0] tick,
                                                      input logic [7:0] peer,
                                                      input logic [7:0] buttons);
      frame_result_type     r;
      int                   free_idx;
      int                   low_idx;
      int                   auth_idx;
      tkifb_pkg::frame_type f;
      r = '0;
      free_idx = -1;
      low_idx = -1;
      auth_idx = -1;
      if (cmd == tkifb_pkg::CMD_ENQUEUE) begin
         for (int i = 0; i < tkifb_pkg::SLOTS; i++) begin
            if (slot_held[i]) begin
               if (slot_data[i].tick == tick && slot_data[i].peer == peer) begin
                  slot_data[i].buttons = buttons;
                  r.status = tkifb_pkg::ST_REPLACED;
                  return r;
               end
            end else if (free_idx < 0) begin
               free_idx = i;
            end
         end
         if (free_idx < 0) begin
            r.status = tkifb_pkg::ST_DROPPED;
         end else begin
            slot_held[free_idx] = 1'b1;
            slot_data[free_idx] = {tick, peer, buttons};
            r.status = tkifb_pkg::ST_NEW;
         end
         return r;
      end
      for (int i = 0; i < tkifb_pkg::SLOTS; i++) begin
         if (slot_held[i] && slot_data[i].tick == tick) begin
            if (low_idx < 0 || slot_data[i].peer < slot_data[low_idx].peer) begin
               low_idx = i;
            end
            if (auth_on && slot_data[i].peer == auth_id) begin
               auth_idx = i;
            end
         end
      end
      if (low_idx < 0) begin
         r.status = tkifb_pkg::ST_NONE;
         return r;
      end
      f = slot_data[(auth_idx >= 0) ? auth_idx : low_idx];
      for (int i = 0; i < tkifb_pkg::SLOTS; i++) begin
         if (slot_held[i] && slot_data[i].tick == tick) begin
            slot_held[i] = 1'b0;
         end
      end
      r.status   = tkifb_pkg::ST_TAKEN;
      r.tick     = f.tick;
      r.peer     = 8'(f.peer);
      r.buttons  = 8'(f.buttons);
      r.forward  = f.buttons[0];
      r.backward = f.buttons[1];
      r.left     = f.buttons[2];
      r.right    = f.buttons[3];
      return r;
   endfunction

   // Every request yields exactly one result, so results pair with requests in order.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tkifb_pkg::SLOTS; i++) begin
            slot_held[i] = 1'b0;
         end
         auth_on = 1'b0;
         auth_id = '0;
         frame_result_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_result_q.size() == 0) begin
               report_mismatch($sformatf("result with status %0d and no request waiting",
                                         rsp_status));
            end else begin
               want_result = frame_result_q.pop_front();
               check_field("status", 32'(rsp_status), 32'(want_result.status));
               check_field("out_tick", rsp_out_tick, want_result.tick);
               check_field("out_peer", 32'(rsp_out_peer), 32'(want_result.peer));
               check_field("out_buttons", 32'(rsp_out_buttons), 32'(want_result.buttons));
               check_field("ahead", 32'(rsp_ahead), 32'(want_result.forward));
               check_field("reverse", 32'(rsp_reverse), 32'(want_result.backward));
               check_field("steer_left", 32'(rsp_steer_left), 32'(want_result.left));
               check_field("steer_right", 32'(rsp_steer_right), 32'(want_result.right));
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tkifb_pkg::CSR_AUTH_ENABLE: auth_on = csr_wdata[0];
               tkifb_pkg::CSR_AUTH_PEER:   auth_id = csr_wdata[7:0];
               default:                    ;
            endcase
         end
         if (req_valid && req_ready) begin
            frame_result_q = {frame_result_q,
                              serve_request(req_command, req_tick, req_peer, req_buttons)};
         end
      end
      outstanding <= frame_result_q.size();
   end

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 75;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_command = tkifb_pkg::CMD_ENQUEUE;
   logic [31:0]                       req_tick = '0;
   logic [7:0]                        req_peer = '0;
   logic [7:0]                        req_buttons = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [2:0]                        rsp_status;
   logic [31:0]                       rsp_out_tick;
   logic [7:0]                        rsp_out_peer;
   logic [7:0]                        rsp_out_buttons;
   logic                              rsp_ahead;
   logic                              rsp_reverse;
   logic                              rsp_steer_left;
   logic                              rsp_steer_right;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tkifb_pkg::CSR_INDEX_W-1:0] csr_index = tkifb_pkg::CSR_AUTH_ENABLE;
   logic [tkifb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   int                                fail_count;
   int                                outstanding;

   logic                              back_to_back = 1'b0;
   logic [7:0]                        auth_peer_set = '0;
   int                                cycle_count = 0;
   int                                req_count = 0;
   int                                take_count = 0;
   int                                setting_count = 0;

   tick_keyed_input_frame_buffer_unit u_dut (.*);

   frame_store_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out with %0d results still awaited.", outstanding);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int draw_wait();
      if (back_to_back) begin
         return 0;
      end
      return int'($urandom_range(0, 18));
   endfunction

   function automatic logic [31:0] pick_tick();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom_range(0, 11);
      endcase
   endfunction

   function automatic logic [7:0] pick_peer();
      case ($urandom_range(0, 4))
         0:       return auth_peer_set;
         1:       return 8'($urandom());
         2:       return 8'hFF;
         default: return 8'($urandom_range(0, 5));
      endcase
   endfunction

   task automatic issue_request(input logic cmd, input logic [31:0] tick,
                                input logic [7:0] peer, input logic [7:0] buttons);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_tick    <= tick;
      req_peer    <= peer;
      req_buttons <= buttons;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
      if (cmd == tkifb_pkg::CMD_TAKE) begin
         take_count++;
      end
   endtask

   task automatic take_frame(input logic [31:0] tick);
      issue_request(tkifb_pkg::CMD_TAKE, tick, 8'($urandom()), 8'($urandom()));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic enable, input logic [7:0] peer);
      csr_valid <= 1'b1;
      csr_index <= tkifb_pkg::CSR_AUTH_ENABLE;
      csr_wdata <= {7'd0, enable};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= tkifb_pkg::CSR_AUTH_PEER;
      csr_wdata <= peer;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      auth_peer_set = peer;
      setting_count++;
   endtask

   task automatic run_random_phase(input int n);
      int          start;
      int          group;
      logic [31:0] tick;
      start = req_count;
      while (req_count - start < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               tick = pick_tick();
               group = $urandom_range(1, 5);
               repeat (group) begin
                  issue_request(tkifb_pkg::CMD_ENQUEUE, tick, pick_peer(), 8'($urandom()));
               end
               if ($urandom_range(0, 4) != 0) begin
                  take_frame(tick);
               end
            end
            6, 7: take_frame(pick_tick());
            default: begin
               issue_request(tkifb_pkg::CMD_ENQUEUE, pick_tick(), pick_peer(),
                             8'($urandom()));
            end
         endcase
      end
   endtask

   initial begin : rsp_side
      int stall;
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_settings(1'b0, 8'h00);
      take_frame(32'h0);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'h0, 8'h00, 8'h00);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 8'hFF, 8'h0F);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 8'h00, 8'hA5);
      wait_idle();

      write_settings(1'b1, 8'hFF);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd9, 8'd7, 8'h01);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd9, 8'd3, 8'h02);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd9, 8'd200, 8'h04);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd10, 8'd4, 8'h08);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd10, 8'd9, 8'h10);
      for (int i = 0; i < 8; i++) begin
         issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd11 + i, 8'(i), 8'(8'h11 * i));
      end
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd30, 8'd1, 8'h5A);
      issue_request(tkifb_pkg::CMD_ENQUEUE, 32'd9, 8'd3, 8'hF0);
      take_frame(32'hFFFF_FFFF);
      take_frame(32'd9);
      take_frame(32'h0);
      take_frame(32'h0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p)
            0:       write_settings(1'b0, 8'h00);
            1:       write_settings(1'b1, 8'h00);
            2:       write_settings(1'b1, 8'hFF);
            3:       write_settings(1'b0, 8'hAA);
            default: write_settings(1'b1, 8'($urandom_range(0, 5)));
         endcase
         back_to_back = (p == 2);
         run_random_phase(PHASE_ITEMS);
      end
      wait_idle();
      back_to_back = 1'b0;
      repeat (60) @(posedge clock);

      $display("Sent %0d requests, %0d of them takes, under %0d register settings.",
               req_count, take_count, setting_count);
      $display("Both channels stalled 0 to 18 cycles per item, one phase back to back.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tkifb_pkg.sv
rtl/core/tkifb_ctrl.sv
rtl/core/tkifb_dp.sv
rtl/core/tick_keyed_input_frame_buffer_unit.sv
tb/frame_store_checker.sv
tb/testbench.sv
